// File: design/eul_pkg.sv
// eul_pkg: shared constants for the totient block.
// Used by eul_divider and euler_totient; no dependencies.
package eul_pkg;

   // Default width of the input value and of the result word.
   localparam int unsigned VALUE_BITS_DEF = 31;

   // First trial divisor.
   localparam int unsigned FIRST_DIVISOR = 2;

endpackage

// File: design/eul_divider.sv
// eul_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on eul_pkg for the default width.
module eul_divider #(
   parameter int unsigned W = eul_pkg::VALUE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   import eul_pkg::*;

   localparam int unsigned CW = $clog2(W + 1);

   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [W-1:0]  rem_ff;
   logic [W-1:0]  quo_ff;
   logic [W-1:0]  div_ff;

   logic [W:0]    shifted;
   logic [W:0]    trial;
   logic          fits;

   // partial remainder shifted left, next dividend bit brought down
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, div_ff};
      fits    = (shifted >= {1'b0, div_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            cnt_ff <= CW'(W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[W-2:0], fits};
         rem_ff <= fits ? trial[W-1:0] : shifted[W-1:0];
      end
   end

   assign busy      = (cnt_ff != '0);
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: design/euler_totient.sv
// euler_totient: Euler's totient of one word by trial division.
// Depends on eul_pkg and eul_divider.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+-------------------------------------
//  request  | start, busy, req_n_value      | word taken when start=1 and busy=0
//  response | rsp_valid, rsp_totient        | one-cycle strobe, cannot be stalled
//
// Work: every trial step is one division on the shared divider, and a new
//   division is issued only after the previous one is done. Worst case near
//   46341 divisions for 31-bit primes. The single bit-serial divider sets the
//   time per word.
// Reset: synchronous, active high; returns to idle, drops busy and rsp_valid.
// Stalls: none on the response side; busy stays high until the result strobe.
module euler_totient #(
   parameter int unsigned VALUE_BITS = eul_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_n_value,
   output logic                  rsp_valid,
   output logic [VALUE_BITS-1:0] rsp_totient
);
   import eul_pkg::*;

   localparam int unsigned W = VALUE_BITS;

   // State names what the outstanding division computes.
   //   S_TRY   : rest / d   (loop test d <= rest/d, and divisibility)
   //   S_SCALE : acc / d    (acc *= (d-1)/d is acc - acc/d, exact here)
   //   S_STRIP : rest / d   (keep dividing d out while it divides)
   //   S_LAST  : acc / rest (leftover prime)
   typedef enum logic [2:0] {
      S_IDLE,
      S_TRY,
      S_SCALE,
      S_STRIP,
      S_LAST
   } state_type;

   state_type     state_ff;
   logic [W-1:0]  rest_ff;
   logic [W-1:0]  acc_ff;
   logic [W-1:0]  d_ff;
   logic [W-1:0]  d_in;
   logic          go_ff;
   logic [W-1:0]  opa_ff;
   logic [W-1:0]  opb_ff;
   logic          rsp_valid_ff;
   logic [W-1:0]  rsp_totient_ff;

   logic          div_busy;
   logic          div_done;
   logic [W-1:0]  div_quo;
   logic [W-1:0]  div_rem;

   eul_divider #(
      .W (W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (go_ff),
      .dividend  (opa_ff),
      .divisor   (opb_ff),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // d never exceeds sqrt(n) when stepped, so d+1 cannot wrap
   assign d_in = d_ff + W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  rest_ff  <= req_n_value;
                  acc_ff   <= req_n_value;
                  d_ff     <= W'(FIRST_DIVISOR);
                  opa_ff   <= req_n_value;
                  opb_ff   <= W'(FIRST_DIVISOR);
                  go_ff    <= 1'b1;
                  state_ff <= S_TRY;
               end
            end
            S_TRY: begin
               if (div_done) begin
                  priority if (d_ff > div_quo) begin
                     // d*d > rest: trial loop over
                     if (rest_ff > W'(1)) begin
                        opa_ff   <= acc_ff;
                        opb_ff   <= rest_ff;
                        go_ff    <= 1'b1;
                        state_ff <= S_LAST;
                     end else begin
                        rsp_totient_ff <= acc_ff;
                        rsp_valid_ff   <= 1'b1;
                        state_ff       <= S_IDLE;
                     end
                  end else if (div_rem == '0) begin
                     // d divides: take out one factor now, scale acc next
                     rest_ff  <= div_quo;
                     opa_ff   <= acc_ff;
                     opb_ff   <= d_ff;
                     go_ff    <= 1'b1;
                     state_ff <= S_SCALE;
                  end else begin
                     d_ff     <= d_in;
                     opa_ff   <= rest_ff;
                     opb_ff   <= d_in;
                     go_ff    <= 1'b1;
                     state_ff <= S_TRY;
                  end
               end
            end
            S_SCALE: begin
               if (div_done) begin
                  acc_ff   <= acc_ff - div_quo;
                  opa_ff   <= rest_ff;
                  opb_ff   <= d_ff;
                  go_ff    <= 1'b1;
                  state_ff <= S_STRIP;
               end
            end
            S_STRIP: begin
               if (div_done) begin
                  if (div_rem == '0) begin
                     rest_ff <= div_quo;
                     opa_ff  <= div_quo;
                     opb_ff  <= d_ff;
                     go_ff   <= 1'b1;
                  end else begin
                     d_ff     <= d_in;
                     opa_ff   <= rest_ff;
                     opb_ff   <= d_in;
                     go_ff    <= 1'b1;
                     state_ff <= S_TRY;
                  end
               end
            end
            S_LAST: begin
               if (div_done) begin
                  rsp_totient_ff <= acc_ff - div_quo;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_totient = rsp_totient_ff;

   // divider is only kicked when idle
   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      go_ff |-> !div_busy)
      else $error("divider issued while still running");

   // every result follows a finished division
   a_rsp_after_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(div_done))
      else $error("result strobe without a finished division");

   // an accepted word always starts a division next cycle
   a_accept_go: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (go_ff && busy))
      else $error("accepted word did not start the divider");

   // trial divisor never below two while working
   a_d_min: assert property (@(posedge clock) disable iff (reset)
      busy |-> (d_ff >= W'(FIRST_DIVISOR)))
      else $error("trial divisor below two");

   // strobe lasts exactly one cycle
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

endmodule
